>>> rtl/core/mebf_pkg.sv
// Package for the mono expansion blit: field widths, codes and shared structs.
`default_nettype none

package mebf_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PIXELS_PER_BYTE = 8;
    localparam int LANES           = PIXELS_PER_BYTE;
    localparam int LANE_W          = $clog2(LANES);
    localparam int COLOR_W         = 32;
    localparam int ADDR_W          = 32;
    localparam int STRIDE_W        = 20;
    localparam int PB_W            = 3;
    localparam int SIZE_W          = 3;
    localparam int ROW_W           = COORD_BITS + 1;
    localparam int XPROD_W         = COORD_BITS + 2 + PB_W;
    localparam int BPR_W           = COORD_BITS - LANE_W + 1;

    localparam int IN_DATA_W       = 152;
    localparam int OUT_DATA_W      = 72;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = STRIDE_W;

    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_OPAQUE = 2'd1;
    localparam logic [1:0] MODE_MASKED = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_INHIBIT = 3'd4;

    localparam logic [PB_W-1:0] PB_BYTE = 3'd1;
    localparam logic [PB_W-1:0] PB_HALF = 3'd2;
    localparam logic [PB_W-1:0] PB_RGB  = 3'd3;
    localparam logic [PB_W-1:0] PB_WORD = 3'd4;

    localparam logic [PB_W-1:0]       RST_PIXEL_BYTES   = 3'd4;
    localparam logic [STRIDE_W-1:0]   RST_ROW_STRIDE    = 20'd4096;
    localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = 16'd1024;
    localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = 16'd768;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] base_col;
        logic [COORD_BITS-1:0] draw_cols;
        logic [COORD_BITS-1:0] origin_col;
        logic [ROW_W-1:0]      row;
        logic [STRIDE_W-1:0]   stride;
        logic [PB_W-1:0]       pix_bytes;
        logic [COLOR_W-1:0]    fg;
        logic [COLOR_W-1:0]    bg;
        logic [LANES-1:0]      bits;
        logic [LANES-1:0]      mask;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [COLOR_W-1:0] color;
        logic [XPROD_W-1:0] xprod;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0]  lane;
        logic [ADDR_W-1:0]  rowbase;
        logic [PB_W-1:0]    pix_bytes;
    } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/mebf_ctrl.sv
// Command control: configuration registers, header latch, row/byte counters, job register.
`default_nettype none

module mebf_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mebf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mebf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tuser,
    input  wire logic [mebf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s2_ready,
    output logic                                   s_tready,
    output logic                                   job_valid,
    output mebf_pkg::job_t                         job
);
    import mebf_pkg::*;

    logic [PB_W-1:0]       pix_bytes_reg;
    logic [STRIDE_W-1:0]   row_stride_reg;
    logic [COORD_BITS-1:0] screen_width_reg;
    logic [COORD_BITS-1:0] screen_height_reg;
    logic                  write_inhibit_reg;

    logic [1:0]            cmd_mode_reg,  cmd_mode_next;
    logic                  suppress_reg,  suppress_next;
    logic [BPR_W-1:0]      byte_cnt_reg,  byte_cnt_next;
    logic [COORD_BITS-1:0] row_cnt_reg,   row_cnt_next;
    logic                  job_valid_reg, job_valid_next;

    logic [COORD_BITS-1:0] origin_col_reg, origin_row_reg;
    logic [COORD_BITS-1:0] draw_cols_reg,  draw_rows_reg;
    logic [BPR_W-1:0]      bpr_reg;
    logic [COLOR_W-1:0]    fg_reg, bg_reg;
    job_t                  job_reg;

    logic [1:0]            in_mode;
    logic [COORD_BITS-1:0] in_x, in_y, in_w, in_h;
    logic [COLOR_W-1:0]    in_fg, in_bg;
    logic [LANES-1:0]      in_bits, in_mask;

    logic                  accept, hdr_accept, data_push;
    logic                  hdr_sup, hdr_expand;
    logic [COORD_BITS:0]   w_sum7;
    logic [BPR_W-1:0]      hdr_bpr;
    logic [COORD_BITS-1:0] hdr_w, hdr_h;
    logic [BPR_W-1:0]      bc_inc;
    logic [COORD_BITS:0]   rc_inc;

    assign in_mode = s_tdata[1:0];
    assign in_x    = s_tdata[17:2];
    assign in_y    = s_tdata[33:18];
    assign in_w    = s_tdata[49:34];
    assign in_h    = s_tdata[65:50];
    assign in_fg   = s_tdata[97:66];
    assign in_bg   = s_tdata[129:98];
    assign in_bits = s_tdata[137:130];
    assign in_mask = s_tdata[145:138];

    assign s_tready   = !job_valid_reg || s2_ready;
    assign accept     = s_tvalid && s_tready;
    assign hdr_accept = accept && !s_tuser;
    assign data_push  = accept && s_tuser && !suppress_reg;

    assign w_sum7  = {1'b0, in_w} + (COORD_BITS+1)'(PIXELS_PER_BYTE - 1);
    assign hdr_bpr = w_sum7[COORD_BITS:LANE_W];

    always_comb
    begin
        hdr_sup    = write_inhibit_reg || (in_mode == MODE_RSVD);
        hdr_expand = (in_mode == MODE_OPAQUE) || (in_mode == MODE_MASKED);
        hdr_w      = in_w;
        hdr_h      = in_h;
        if (hdr_expand)
        begin
            if (({1'b0, in_x} + {1'b0, in_w}) > {1'b0, screen_width_reg})
            begin
                if (in_x >= screen_width_reg)
                    hdr_sup = 1'b1;
                else
                    hdr_w = screen_width_reg - in_x;
            end
            if (({1'b0, in_y} + {1'b0, in_h}) > {1'b0, screen_height_reg})
            begin
                if (in_y >= screen_height_reg)
                    hdr_sup = 1'b1;
                else
                    hdr_h = screen_height_reg - in_y;
            end
        end
        if ((hdr_w == '0) || (hdr_h == '0))
            hdr_sup = 1'b1;
    end

    assign bc_inc = byte_cnt_reg + BPR_W'(1);
    assign rc_inc = {1'b0, row_cnt_reg} + (COORD_BITS+1)'(1);

    always_comb
    begin
        cmd_mode_next = cmd_mode_reg;
        suppress_next = suppress_reg;
        byte_cnt_next = byte_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        if (hdr_accept)
        begin
            cmd_mode_next = in_mode;
            suppress_next = hdr_sup;
            byte_cnt_next = '0;
            row_cnt_next  = '0;
        end
        else if (data_push)
        begin
            byte_cnt_next = bc_inc;
            if (bc_inc >= bpr_reg)
            begin
                byte_cnt_next = '0;
                row_cnt_next  = rc_inc[COORD_BITS-1:0];
                if (rc_inc >= {1'b0, draw_rows_reg})
                    suppress_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (s_tready)
            job_valid_next = data_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_bytes_reg     <= RST_PIXEL_BYTES;
            row_stride_reg    <= RST_ROW_STRIDE;
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            write_inhibit_reg <= 1'b0;
            cmd_mode_reg      <= MODE_FILL;
            suppress_reg      <= 1'b1;
            byte_cnt_reg      <= '0;
            row_cnt_reg       <= '0;
            job_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PIXEL_BYTES:   pix_bytes_reg     <= cfg_data[PB_W-1:0];
                    REG_ROW_STRIDE:    row_stride_reg    <= cfg_data[STRIDE_W-1:0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[COORD_BITS-1:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[COORD_BITS-1:0];
                    REG_WRITE_INHIBIT: write_inhibit_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            cmd_mode_reg  <= cmd_mode_next;
            suppress_reg  <= suppress_next;
            byte_cnt_reg  <= byte_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_accept)
        begin
            origin_col_reg <= in_x;
            origin_row_reg <= in_y;
            draw_cols_reg  <= hdr_w;
            draw_rows_reg  <= hdr_h;
            bpr_reg        <= hdr_bpr;
            fg_reg         <= in_fg;
            bg_reg         <= in_bg;
        end
        if (data_push)
        begin
            job_reg.mode       <= cmd_mode_reg;
            job_reg.base_col   <= {byte_cnt_reg[COORD_BITS-LANE_W-1:0], LANE_W'(0)};
            job_reg.draw_cols  <= draw_cols_reg;
            job_reg.origin_col <= origin_col_reg;
            job_reg.row        <= {1'b0, origin_row_reg} + {1'b0, row_cnt_reg};
            job_reg.stride     <= row_stride_reg;
            job_reg.pix_bytes  <= pix_bytes_reg;
            job_reg.fg         <= fg_reg;
            job_reg.bg         <= bg_reg;
            job_reg.bits       <= in_bits;
            job_reg.mask       <= in_mask;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

>>> rtl/core/mebf_lane.sv
// One pixel lane: column clip, mode select, color pick and pixel offset in the row.
`default_nettype none

module mebf_lane (
    input  mebf_pkg::job_t                   job,
    input  wire logic [mebf_pkg::LANE_W-1:0] lane_idx,
    output mebf_pkg::lane_t                  res
);
    import mebf_pkg::*;

    logic [COORD_BITS:0]   col;
    logic [COORD_BITS+1:0] x;
    logic [LANE_W-1:0]     bit_pos;
    logic                  pix_bit, mask_bit, in_range, pb_ok, mode_ok;

    assign col      = {1'b0, job.base_col} + {{(COORD_BITS+1-LANE_W){1'b0}}, lane_idx};
    assign x        = {2'b0, job.origin_col} + {1'b0, col};
    assign bit_pos  = LANE_W'(LANES - 1) - lane_idx;
    assign pix_bit  = job.bits[bit_pos];
    assign mask_bit = job.mask[bit_pos];
    assign in_range = col < {1'b0, job.draw_cols};
    assign pb_ok    = (job.pix_bytes >= PB_BYTE) && (job.pix_bytes <= PB_WORD);

    always_comb
    begin
        case (job.mode)
            MODE_FILL:   mode_ok = 1'b1;
            MODE_OPAQUE: mode_ok = 1'b1;
            MODE_MASKED: mode_ok = mask_bit;
            default:     mode_ok = 1'b0;
        endcase
    end

    assign res.en    = in_range && pb_ok && mode_ok;
    assign res.color = ((job.mode == MODE_OPAQUE) && !pix_bit) ? job.bg : job.fg;
    assign res.xprod = {{PB_W{1'b0}}, x} * {{(XPROD_W-PB_W){1'b0}}, job.pix_bytes};

endmodule

`default_nettype wire

>>> rtl/core/mebf_merge.sv
// Merge stage: serializes the enabled lanes into framebuffer writes through an output register.
`default_nettype none

module mebf_merge (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s2_valid,
    input  mebf_pkg::stage_t                     s2,
    output logic                                 take,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mebf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);
    import mebf_pkg::*;

    logic [LANES-1:0]   ser_en_reg, ser_en_next;
    logic [1:0]         sub_reg, sub_next;
    stage_t             ser_reg;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_offset_reg;
    logic [COLOR_W-1:0] out_data_reg;
    logic [SIZE_W-1:0]  out_size_reg;
    logic               out_last_reg;

    logic               busy, emit, last, done_pix;
    logic [LANE_W-1:0]  sel;
    logic [LANES-1:0]   rest, s2_en;
    lane_t              cur;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] wdata;
    logic [SIZE_W-1:0]  wsize;

    always_comb
    begin
        sel = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (ser_en_reg[i])
                sel = LANE_W'(i);
        end
        for (int i = 0; i < LANES; i++)
            s2_en[i] = s2.lane[i].en;
    end

    assign cur      = ser_reg.lane[sel];
    assign busy     = |ser_en_reg;
    assign emit     = busy && (!out_valid_reg || m_tready);
    assign done_pix = (ser_reg.pix_bytes != PB_RGB) || (sub_reg == 2'd2);
    assign rest     = ser_en_reg & ~(LANES'(1) << sel);
    assign last     = done_pix && (rest == '0);
    assign take     = s2_valid && (!busy || (emit && last));
    assign addr     = ser_reg.rowbase + {{(ADDR_W-XPROD_W){1'b0}}, cur.xprod}
                      + {{(ADDR_W-2){1'b0}}, sub_reg};

    always_comb
    begin
        wdata = cur.color;
        wsize = ser_reg.pix_bytes;
        case (ser_reg.pix_bytes)
            PB_BYTE: wdata = {24'b0, cur.color[7:0]};
            PB_HALF: wdata = {16'b0, cur.color[15:0]};
            PB_RGB:
            begin
                wsize = PB_BYTE;
                case (sub_reg)
                    2'd0:    wdata = {24'b0, cur.color[23:16]};
                    2'd1:    wdata = {24'b0, cur.color[15:8]};
                    default: wdata = {24'b0, cur.color[7:0]};
                endcase
            end
            default: wdata = cur.color;
        endcase
    end

    always_comb
    begin
        ser_en_next = ser_en_reg;
        sub_next    = sub_reg;
        if (take)
        begin
            ser_en_next = s2_en;
            sub_next    = 2'd0;
        end
        else if (emit)
        begin
            if (done_pix)
            begin
                ser_en_next = rest;
                sub_next    = 2'd0;
            end
            else
                sub_next = sub_reg + 2'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_en_reg    <= '0;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ser_en_reg    <= ser_en_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            ser_reg <= s2;
        if (emit)
        begin
            out_offset_reg <= addr;
            out_data_reg   <= wdata;
            out_size_reg   <= wsize;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W-ADDR_W-COLOR_W-SIZE_W)'(0), out_size_reg, out_data_reg,
                       out_offset_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/mono_expand_blit_fill.sv
// Top level of the mono expansion blit: control, eight pixel lanes, row multiply, merge.
`default_nettype none

// A header transaction latches the command and causes no write. Each bitmap byte is split
// over eight pixel lanes; the merge stage then sends one framebuffer write per clock
// through its output register while m_tready holds, so a byte causes up to 8 writes at
// 1, 2 or 4 bytes per pixel and up to 24 at 3 bytes per pixel, where each pixel is three
// byte writes. The single write port bounds the throughput; the next byte is accepted
// while the current one drains, and the first write of a byte passes through the job
// register, the stage-2 register, the serializer register and the output register.
// tlast marks the final write of each byte.
module mono_expand_blit_fill (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mebf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mebf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // op_mode, dest_x, dest_y, area_width, area_height, fore_color, back_color,
    // bitmap_byte, mask_byte
    input  wire logic [mebf_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // byte_offset, write_data, write_size
    output logic [mebf_pkg::OUT_DATA_W-1:0]        m_tdata,
    // last_write
    output logic                                   m_tlast
);
    import mebf_pkg::*;

    logic   job_valid, s2_ready, take, s2_any_en;
    job_t   job;
    lane_t  lane_res [LANES];
    logic   s2_valid_reg, s2_valid_next;
    stage_t s2_reg;
    logic [ADDR_W+COORD_BITS+4:0] row_prod;

    mebf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s2_ready  (s2_ready),
        .s_tready  (s_tready),
        .job_valid (job_valid),
        .job       (job)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mebf_lane u_lane (
            .job      (job),
            .lane_idx (LANE_W'(g)),
            .res      (lane_res[g])
        );
    end

    assign row_prod = {{(ADDR_W+COORD_BITS+5-STRIDE_W){1'b0}}, job.stride}
                      * {{(ADDR_W+COORD_BITS+5-ROW_W){1'b0}}, job.row};

    assign s2_ready = !s2_valid_reg || take;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
            s2_valid_next = job_valid;
        s2_any_en = 1'b0;
        for (int i = 0; i < LANES; i++)
            s2_any_en = s2_any_en | s2_reg.lane[i].en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && s2_ready)
        begin
            for (int i = 0; i < LANES; i++)
                s2_reg.lane[i] <= lane_res[i];
            s2_reg.rowbase   <= row_prod[ADDR_W-1:0];
            s2_reg.pix_bytes <= job.pix_bytes;
        end
    end

    mebf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid_reg),
        .s2       (s2_reg),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> !job_valid)
        else $error("header transaction left a job in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_any_en) |->
        (s2_reg.pix_bytes == PB_BYTE || s2_reg.pix_bytes == PB_HALF ||
         s2_reg.pix_bytes == PB_RGB  || s2_reg.pix_bytes == PB_WORD))
        else $error("lane enabled with unsupported pixel size");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[66:64] == PB_BYTE || m_tdata[66:64] == PB_HALF ||
                      m_tdata[66:64] == PB_WORD))
        else $error("write size not 1, 2 or 4");

endmodule

`default_nettype wire
